/* rtl/core/fpcr_pkg.sv */
// ----------------------------------------------------------------------------
// fpcr_pkg
// Shared constants, command/status types and the level conversion for the
// framed drive-level command receiver.
// ----------------------------------------------------------------------------
package fpcr_pkg;

   localparam int BYTE_W          = 8;
   localparam int LEVEL_W         = 7;
   localparam int DEF_MAX_PAYLOAD = 8;

   localparam logic [BYTE_W-1:0]  BYTE_START = 8'h02;
   localparam logic [BYTE_W-1:0]  BYTE_END   = 8'h03;
   localparam logic [BYTE_W-1:0]  CMD_LEFT   = 8'h04;
   localparam logic [BYTE_W-1:0]  CMD_RIGHT  = 8'h05;
   localparam logic [BYTE_W-1:0]  FULL_SCALE = 8'd100;

   // Controller to datapath
   typedef struct packed {
      logic take_byte;   // a request transfer completes this cycle
      logic start_walk;  // end byte closes an open frame
      logic rd_cmd;      // read the command byte of the current pair
      logic rd_val;      // read the value byte of the current pair
      logic latch_cmd;   // capture the command byte just read
      logic apply_val;   // apply the value byte just read
      logic load_rsp;    // load the response register
   } fpcr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic end_close;   // current byte is an end byte and a frame is open
      logic has_pairs;   // buffered payload holds at least one full pair
      logic more_pairs;  // another full pair follows the current one
      logic slot_free;   // response register can take a new result
   } fpcr_status_type;

   // Drive level in percent: 100 minus the value, saturated at zero
   function automatic logic [LEVEL_W-1:0] level_of(input logic [BYTE_W-1:0] value);
      logic [BYTE_W-1:0] diff;
      diff = FULL_SCALE - value;
      if (value >= FULL_SCALE) begin
         return '0;
      end
      return diff[LEVEL_W-1:0];
   endfunction

endpackage

/* rtl/core/fpcr_datapath.sv */
// ----------------------------------------------------------------------------
// fpcr_datapath
// Frame tracking, payload memory, pair walk registers, drive levels and the
// response register.
// ----------------------------------------------------------------------------
module fpcr_datapath import fpcr_pkg::*; #(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  fpcr_cmd_type        cmd,
   output fpcr_status_type     status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [LEVEL_W-1:0]  rsp_left_level,
   output logic [LEVEL_W-1:0]  rsp_right_level,
   output logic                rsp_left_updated,
   output logic                rsp_right_updated
);

   localparam int AW = $clog2(MAX_PAYLOAD);
   localparam int CW = $clog2(MAX_PAYLOAD + 1);

   logic                frame_open_ff;
   logic [CW-1:0]       count_ff;
   logic [BYTE_W-1:0]   mem [MAX_PAYLOAD];
   logic [BYTE_W-1:0]   rd_data_ff;
   logic [AW-1:0]       idx_ff;
   logic [BYTE_W-1:0]   cmd_byte_ff;
   logic [LEVEL_W-1:0]  left_drive_ff;
   logic [LEVEL_W-1:0]  right_drive_ff;
   logic                left_upd_ff;
   logic                right_upd_ff;
   logic                rsp_valid_ff;
   logic [LEVEL_W-1:0]  rsp_left_ff;
   logic [LEVEL_W-1:0]  rsp_right_ff;
   logic                rsp_lu_ff;
   logic                rsp_ru_ff;

   logic                is_start;
   logic                is_end;
   logic                wr_en;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;

   assign is_start = (req_rx_byte == BYTE_START);
   assign is_end   = (req_rx_byte == BYTE_END);
   assign wr_en    = cmd.take_byte && !is_start && !is_end && frame_open_ff
                     && (count_ff < CW'(MAX_PAYLOAD));
   assign rd_en    = cmd.rd_cmd || cmd.rd_val;
   assign rd_addr  = cmd.rd_val ? idx_ff + AW'(1) : idx_ff;

   assign status.end_close  = is_end && frame_open_ff;
   assign status.has_pairs  = (count_ff >= CW'(2));
   assign status.more_pairs = ((CW+1)'(idx_ff) + (CW+1)'(3)) < (CW+1)'(count_ff);
   assign status.slot_free  = !rsp_valid_ff || !rsp_stall;

   // Payload memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Frame state and payload count
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         count_ff      <= '0;
      end else if (cmd.take_byte) begin
         if (is_start && !frame_open_ff) begin
            frame_open_ff <= 1'b1;
            count_ff      <= '0;
         end else if (cmd.start_walk) begin
            frame_open_ff <= 1'b0;
         end else if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   // Pair walk and drive levels
   always_ff @(posedge clock) begin
      if (reset) begin
         left_drive_ff  <= '0;
         right_drive_ff <= '0;
         left_upd_ff    <= 1'b0;
         right_upd_ff   <= 1'b0;
      end else if (cmd.start_walk) begin
         left_upd_ff  <= 1'b0;
         right_upd_ff <= 1'b0;
      end else if (cmd.apply_val) begin
         if (cmd_byte_ff == CMD_LEFT) begin
            left_drive_ff <= level_of(rd_data_ff);
            left_upd_ff   <= 1'b1;
         end else if (cmd_byte_ff == CMD_RIGHT) begin
            right_drive_ff <= level_of(rd_data_ff);
            right_upd_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_walk) begin
         idx_ff <= '0;
      end else if (cmd.apply_val) begin
         idx_ff <= idx_ff + AW'(2);
      end
      if (cmd.latch_cmd) begin
         cmd_byte_ff <= rd_data_ff;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_left_ff  <= left_drive_ff;
         rsp_right_ff <= right_drive_ff;
         rsp_lu_ff    <= left_upd_ff;
         rsp_ru_ff    <= right_upd_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_level    = rsp_left_ff;
   assign rsp_right_level   = rsp_right_ff;
   assign rsp_left_updated  = rsp_lu_ff;
   assign rsp_right_updated = rsp_ru_ff;

endmodule

/* rtl/core/fpcr_ctrl.sv */
// ----------------------------------------------------------------------------
// fpcr_ctrl
// Sequencer for byte intake, the command/value pair walk and result hand-off.
// ----------------------------------------------------------------------------
module fpcr_ctrl import fpcr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fpcr_status_type  status,
   output fpcr_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_VAL,
      ST_APPLY,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd            = '0;
      cmd.take_byte  = (state_ff == ST_IDLE) && req_valid;
      cmd.start_walk = cmd.take_byte && status.end_close;
      cmd.rd_cmd     = (state_ff == ST_CMD);
      cmd.rd_val     = (state_ff == ST_VAL);
      cmd.latch_cmd  = (state_ff == ST_VAL);
      cmd.apply_val  = (state_ff == ST_APPLY);
      cmd.load_rsp   = (state_ff == ST_DONE) && status.slot_free;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_walk) begin
               state_in = status.has_pairs ? ST_CMD : ST_DONE;
            end
         end
         ST_CMD:   state_in = ST_VAL;
         ST_VAL:   state_in = ST_APPLY;
         ST_APPLY: state_in = status.more_pairs ? ST_CMD : ST_DONE;
         ST_DONE: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/framed_pwm_command_receiver.sv */
// ----------------------------------------------------------------------------
// framed_pwm_command_receiver
// Start/end framed command receiver that yields left and right drive levels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transfer. 0x02 opens a frame, 0x03
//   closes it, other bytes are buffered (up to MAX_PAYLOAD) while it is open.
//   rsp_* carries one result per closed frame: both drive levels in percent
//   and a flag per side telling whether the frame set that side.
// Timing:
//   Start and payload bytes are taken without a stall; req_stall stays low.
//   An end byte that closes a frame stalls the request side while the
//   controller walks the full command/value pairs (at most MAX_PAYLOAD/2)
//   through the single-read-port payload memory, in states CMD, VAL and
//   APPLY per pair, and then loads the response register in state DONE.
//   rsp_valid is registered from that load.
// Reset:
//   Closes any frame, clears the payload count, zeroes both drive levels and
//   drops rsp_valid. Payload memory content is not cleared.
// Back-pressure:
//   While rsp_stall holds a pending result, bytes are still taken; a later
//   frame end waits at the hand-off until the response register frees up.
// ----------------------------------------------------------------------------
module framed_pwm_command_receiver import fpcr_pkg::*; #(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic                clock,
   input  logic                reset,
   // request channel: received bytes
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   // response channel: one result per closed frame
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LEVEL_W-1:0]  rsp_left_level,
   output logic [LEVEL_W-1:0]  rsp_right_level,
   output logic                rsp_left_updated,
   output logic                rsp_right_updated
);

   fpcr_cmd_type    cmd;
   fpcr_status_type status;

   // Sequence intake, pair walk and result hand-off
   fpcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold frame state, payload, levels and the response register
   fpcr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_left_level    (rsp_left_level),
      .rsp_right_level   (rsp_right_level),
      .rsp_left_updated  (rsp_left_updated),
      .rsp_right_updated (rsp_right_updated)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: framed drive-level command receiver testbench
// Sends received bytes (directed corner cases, then random frames, broken
// frames and line noise) under random gaps and back-pressure. A scoreboard
// models the frame parser and checks each result in order.
// ----------------------------------------------------------------------------
module tb_top;
   import fpcr_pkg::*;

   // Direction commands carry no level; the receiver skips them
   localparam logic [BYTE_W-1:0] CMD_DIR_FWD = 8'h06;
   localparam logic [BYTE_W-1:0] CMD_DIR_REV = 8'h07;

   localparam int RANDOM_ITEMS = 1200;
   // Longest pair walk plus hand-off, with margin
   localparam int DRAIN_CYCLES = 3 * (DEF_MAX_PAYLOAD / 2) + 2 + 20;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct packed {
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] right_level;
      logic               left_updated;
      logic               right_updated;
   } drive_levels_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the parser state and queues the levels each closed
   // frame should report.
   // -------------------------------------------------------------------------
   class drive_level_scoreboard;
      bit                 frame_open;
      logic [BYTE_W-1:0]  payload_buf [DEF_MAX_PAYLOAD];
      int unsigned        payload_len;
      logic [LEVEL_W-1:0] left_drive;
      logic [LEVEL_W-1:0] right_drive;
      drive_levels_type   pending_levels [$];
      int unsigned        error_count;

      function new();
         frame_open  = 1'b0;
         payload_len = 0;
         left_drive  = '0;
         right_drive = '0;
         error_count = 0;
      endfunction

      // Duty in percent: full scale minus the value, floored at zero
      function logic [LEVEL_W-1:0] duty_percent(logic [BYTE_W-1:0] value);
         logic [BYTE_W-1:0] remainder;
         remainder = FULL_SCALE - value;
         if (value >= FULL_SCALE) begin
            return '0;
         end
         return remainder[LEVEL_W-1:0];
      endfunction

      // Advance the parser by one accepted byte; queue a result on frame close
      function void note_rx_byte(logic [BYTE_W-1:0] rx);
         drive_levels_type result;
         if (rx == BYTE_START) begin
            if (!frame_open) begin
               frame_open  = 1'b1;
               payload_len = 0;
            end
         end else if (rx == BYTE_END) begin
            if (frame_open) begin
               result.left_updated  = 1'b0;
               result.right_updated = 1'b0;
               // Walk whole pairs only; a trailing command has no value
               for (int i = 0; i + 1 < payload_len; i += 2) begin
                  if (payload_buf[i] == CMD_LEFT) begin
                     left_drive = duty_percent(payload_buf[i+1]);
                     result.left_updated = 1'b1;
                  end else if (payload_buf[i] == CMD_RIGHT) begin
                     right_drive = duty_percent(payload_buf[i+1]);
                     result.right_updated = 1'b1;
                  end
               end
               result.left_level  = left_drive;
               result.right_level = right_drive;
               pending_levels.push_back(result);
               frame_open = 1'b0;
            end
         end else if (frame_open && payload_len < DEF_MAX_PAYLOAD) begin
            payload_buf[payload_len] = rx;
            payload_len++;
         end
      endfunction

      // Compare one response transfer with the oldest queued result
      function void check_levels(drive_levels_type got);
         drive_levels_type want;
         if (pending_levels.size() == 0) begin
            $error("unexpected result: left_level %0d right_level %0d",
                   got.left_level, got.right_level);
            error_count++;
            return;
         end
         want = pending_levels.pop_front();
         if (got.left_level !== want.left_level) begin
            $error("left_level: expected %0d, got %0d", want.left_level, got.left_level);
            error_count++;
         end
         if (got.right_level !== want.right_level) begin
            $error("right_level: expected %0d, got %0d", want.right_level,
                   got.right_level);
            error_count++;
         end
         if (got.left_updated !== want.left_updated) begin
            $error("left_updated: expected %0d, got %0d", want.left_updated,
                   got.left_updated);
            error_count++;
         end
         if (got.right_updated !== want.right_updated) begin
            $error("right_updated: expected %0d, got %0d", want.right_updated,
                   got.right_updated);
            error_count++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [LEVEL_W-1:0] rsp_left_level;
   logic [LEVEL_W-1:0] rsp_right_level;
   logic               rsp_left_updated;
   logic               rsp_right_updated;

   drive_level_scoreboard sb = new();

   int unsigned sent_count   = 0;
   bit          steady_flow  = 1'b0;  // no gaps and no stalls while set
   bit          hold_off_req = 1'b0;  // ask the receiver for a long stall
   int unsigned hold_cycles  = 0;
   int unsigned stall_run    = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   framed_pwm_command_receiver uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_level    (rsp_left_level),
      .rsp_right_level   (rsp_right_level),
      .rsp_left_updated  (rsp_left_updated),
      .rsp_right_updated (rsp_right_updated)
   );

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned idle_length();
      int unsigned roll;
      if (steady_flow) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_command();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return CMD_LEFT;
      if (roll < 80) return CMD_RIGHT;
      if (roll < 85) return CMD_DIR_FWD;
      if (roll < 90) return CMD_DIR_REV;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Bias values toward the in-range levels and the saturation edge
   function automatic logic [BYTE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return BYTE_W'($urandom_range(0, 100));
      if (roll < 85) return BYTE_W'($urandom_range(95, 105));
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // -------------------------------------------------------------------------
   // Request side: one byte per call. Hold valid and data until the transfer
   // completes; keep valid high into the next byte when no gap is drawn.
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      int unsigned gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      sb.note_rx_byte(rx);
      sent_count++;
   endtask

   task automatic send_random_frame();
      int unsigned kind;
      int unsigned pairs;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         // Well-formed frame; a few overflow the payload buffer
         send_byte(BYTE_START);
         pairs = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 5);
         repeat (pairs) begin
            send_byte(pick_command());
            send_byte(pick_value());
         end
         if ($urandom_range(0, 4) == 0) begin
            send_byte(pick_command());
         end
         send_byte(BYTE_END);
      end else if (kind < 87) begin
         // Broken frame: no end, maybe a repeated start; the next frame runs on
         send_byte(BYTE_START);
         repeat ($urandom_range(0, 4)) begin
            send_byte($urandom_range(0, 1) ? pick_command() : pick_value());
         end
         if ($urandom_range(0, 1) == 1) begin
            send_byte(BYTE_START);
         end
      end else begin
         // Line noise, sometimes a stray end byte
         repeat ($urandom_range(1, 4)) begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 2) == 0) begin
            send_byte(BYTE_END);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: check every transfer, then choose the stall for the next
   // cycle. A requested hold-off stalls for a long stretch counted here.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         sb.check_levels('{rsp_left_level, rsp_right_level,
                           rsp_left_updated, rsp_right_updated});
      end
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_cycles  = LONG_HOLD_CYCLES;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (steady_flow) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 40);
         stall_run = idle_length();
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // End with no frame open, then payload with no frame open: drop both
      send_byte(BYTE_END);
      send_byte(CMD_LEFT);
      // Full-scale left, saturated right, a start inside the open frame
      send_byte(BYTE_START);
      send_byte(CMD_LEFT);
      send_byte(8'h00);
      send_byte(CMD_RIGHT);
      send_byte(8'hFF);
      send_byte(BYTE_START);
      send_byte(BYTE_END);
      // Direction commands only, then a trailing command with no value
      send_byte(BYTE_START);
      send_byte(CMD_DIR_FWD);
      send_byte(8'h01);
      send_byte(CMD_DIR_REV);
      send_byte(8'h00);
      send_byte(CMD_LEFT);
      send_byte(BYTE_END);
      // Values at 100, 99 and 101, repeated commands, then one byte past
      // the buffer, which the frame drops
      send_byte(BYTE_START);
      send_byte(CMD_LEFT);
      send_byte(8'd100);
      send_byte(CMD_LEFT);
      send_byte(8'd99);
      send_byte(CMD_RIGHT);
      send_byte(8'd101);
      send_byte(CMD_RIGHT);
      send_byte(8'd1);
      send_byte(CMD_LEFT);
      send_byte(BYTE_END);
      // Empty frame
      send_byte(BYTE_START);
      send_byte(BYTE_END);

      // Random part; hold rsp_stall for a long stretch at the start and again when a
      // frame starts just past the midpoint, so results pile up behind the held one
      hold_off_req = 1'b1;
      while (sent_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            steady_flow = ~steady_flow;
         end
         if (sent_count >= RANDOM_ITEMS / 2 && sent_count < RANDOM_ITEMS / 2 + 8) begin
            hold_off_req = 1'b1;
         end
         send_random_frame();
      end
      req_valid   <= 1'b0;
      steady_flow = 1'b0;

      // Drain outstanding results, then watch for strays
      while (sb.pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("framed_pwm_command_receiver: match");
      end else begin
         $display("framed_pwm_command_receiver: mismatch");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("framed_pwm_command_receiver: mismatch");
      $finish;
   end

endmodule
